>>> hw/rtl/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared constants, codes and control types of the contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

   localparam int POOL_UNITS = 1024;
   localparam int ADDR_W     = $clog2(POOL_UNITS);
   localparam int SIZE_W     = ADDR_W + 1;
   localparam int CNT_W      = ADDR_W + 1;
   localparam int POLICY_W   = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 1;

   typedef enum logic [POLICY_W-1:0] {
      POL_FIRST  = 2'd0,
      POL_NEXT   = 2'd1,
      POL_BEST   = 2'd2,
      POL_UNUSED = 2'd3
   } policy_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_FIT_POLICY = '0;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic scan_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic need_scan;
      logic scan_done;
      logic slot_free;
   } status_type;

endpackage

>>> hw/rtl/cfa_if.sv
// ----------------------------------------------------------------------------
// cfa_req_if / cfa_rsp_if
// Valid/ready channels for requests and results of the allocator.
// ----------------------------------------------------------------------------
interface cfa_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [cfa_pkg::SIZE_W-1:0] req_size;
   logic [cfa_pkg::ADDR_W-1:0] free_start;
   modport source (output valid, output op, output req_size, output free_start, input ready);
   modport sink   (input valid, input op, input req_size, input free_start, output ready);
endinterface

interface cfa_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       granted;
   logic [cfa_pkg::ADDR_W-1:0] block_start;
   modport source (output valid, output granted, output block_start, input ready);
   modport sink   (input valid, input granted, input block_start, output ready);
endinterface

>>> hw/rtl/cfa_ram.sv
// ----------------------------------------------------------------------------
// cfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> hw/rtl/cfa_ctrl.sv
// ----------------------------------------------------------------------------
// cfa_ctrl
// Sequencer: clearing pass, request intake, pool scan and result hand-off.
// ----------------------------------------------------------------------------
module cfa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output cfa_pkg::cmd_type    cmd,
   input  cfa_pkg::status_type status
);
   import cfa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.need_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the result slot before touching the table
            if (status.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end
endmodule

>>> hw/rtl/cfa_datapath.sv
// ----------------------------------------------------------------------------
// cfa_datapath
// Size table, skipping pool scan, fit selection, pointer and result register.
// ----------------------------------------------------------------------------
module cfa_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  cfa_pkg::policy_type          policy,
   input  logic                         in_op,
   input  logic [cfa_pkg::SIZE_W-1:0]   in_size,
   input  logic [cfa_pkg::ADDR_W-1:0]   in_free_start,
   input  cfa_pkg::cmd_type             cmd,
   output cfa_pkg::status_type          status,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_granted,
   output logic [cfa_pkg::ADDR_W-1:0]   rsp_block_start
);
   import cfa_pkg::*;

   localparam logic [CNT_W-1:0] POOL_END = CNT_W'(POOL_UNITS);

   // request and outcome
   logic              op_ff;
   logic [SIZE_W-1:0] n_ff;
   logic [ADDR_W-1:0] fs_ff;
   logic              ok_ff, ok_in;
   logic [ADDR_W-1:0] start_ff, start_in;

   // scan state
   logic [CNT_W-1:0]  u_ff, u_in;
   logic [CNT_W-1:0]  run_ff, run_in;
   logic [ADDR_W-1:0] rs_ff, rs_in;
   logic              best_found_ff, best_found_in;
   logic [CNT_W-1:0]  best_len_ff, best_len_in;
   logic [ADDR_W-1:0] best_start_ff, best_start_in;
   logic              low_found_ff, low_found_in;
   logic [ADDR_W-1:0] low_start_ff, low_start_in;
   logic [ADDR_W-1:0] ptr_ff;
   logic [CNT_W-1:0]  clr_ff;

   logic              rsp_valid_ff;
   logic              rsp_granted_ff;
   logic [ADDR_W-1:0] rsp_start_ff;

   // table port
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [SIZE_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [SIZE_W-1:0] rd_data;

   // scan step
   logic              at_end, unit_occ, unit_free;
   logic [CNT_W-1:0]  run_new;
   logic [ADDR_W-1:0] rs_new, p_start;
   logic [CNT_W+1:0]  jump;
   logic [CNT_W-1:0]  next_u, span_p;
   logic              win_low, win_ptr, best_upd, done;
   logic              found;
   logic [ADDR_W-1:0] found_start;
   logic [SIZE_W:0]   np;

   cfa_ram #(.WIDTH(SIZE_W), .DEPTH(POOL_UNITS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      at_end    = (u_ff == POOL_END);
      unit_occ  = !at_end && (rd_data != '0);
      unit_free = !at_end && (rd_data == '0);
      run_new   = run_ff + CNT_W'(1);
      rs_new    = (run_ff == '0) ? u_ff[ADDR_W-1:0] : rs_ff;
      p_start   = (rs_new > ptr_ff) ? rs_new : ptr_ff;
      span_p    = u_ff + CNT_W'(1) - {1'b0, p_start};
      win_low   = unit_free && (run_new >= n_ff);
      win_ptr   = unit_free && (u_ff >= {1'b0, ptr_ff}) && (span_p >= n_ff);
      // a maximal free run closes on an occupied unit or at the pool end
      best_upd  = (unit_occ || at_end) && (run_ff != '0) && (run_ff >= n_ff)
                  && (!best_found_ff || (run_ff <= best_len_ff));
      jump      = {2'b00, u_ff} + {2'b00, rd_data};
      if (unit_occ) begin
         next_u = (jump >= (CNT_W+2)'(POOL_UNITS)) ? POOL_END : jump[CNT_W-1:0];
      end else begin
         next_u = u_ff + CNT_W'(1);
      end

      done        = 1'b0;
      found       = 1'b0;
      found_start = '0;
      unique case (policy)
         POL_FIRST: begin
            if (win_low) begin
               done = 1'b1; found = 1'b1; found_start = rs_new;
            end else if (at_end) begin
               done = 1'b1;
            end
         end
         POL_NEXT: begin
            if (win_ptr) begin
               done = 1'b1; found = 1'b1; found_start = p_start;
            end else if (at_end) begin
               done = 1'b1; found = low_found_ff; found_start = low_start_ff;
            end
         end
         POL_BEST: begin
            if (at_end) begin
               done        = 1'b1;
               found       = best_found_ff || best_upd;
               found_start = best_upd ? rs_ff : best_start_ff;
            end
         end
         POL_UNUSED: begin
            done = 1'b1;
         end
         default: done = 1'b1;
      endcase
   end

   always_comb begin
      u_in          = u_ff;
      run_in        = run_ff;
      rs_in         = rs_ff;
      best_found_in = best_found_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      low_found_in  = low_found_ff;
      low_start_in  = low_start_ff;
      ok_in         = ok_ff;
      start_in      = start_ff;
      if (cmd.load) begin
         u_in          = '0;
         run_in        = '0;
         rs_in         = '0;
         best_found_in = 1'b0;
         best_len_in   = '0;
         best_start_in = '0;
         low_found_in  = 1'b0;
         low_start_in  = '0;
         ok_in         = (in_op == OP_FREE);
         start_in      = (in_op == OP_FREE) ? in_free_start : '0;
      end else if (cmd.scan_step) begin
         u_in = next_u;
         if (unit_free) begin
            run_in = run_new;
            rs_in  = rs_new;
         end else begin
            run_in = '0;
         end
         if (best_upd) begin
            best_found_in = 1'b1;
            best_len_in   = run_ff;
            best_start_in = rs_ff;
         end
         if (win_low && !low_found_ff) begin
            low_found_in = 1'b1;
            low_start_in = rs_new;
         end
         if (done) begin
            ok_in    = found;
            start_in = found ? found_start : '0;
         end
      end
   end

   assign rd_addr = cmd.scan_step ? next_u[ADDR_W-1:0] : '0;
   assign np      = {2'b00, start_ff} + {1'b0, n_ff};

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = start_ff;
      wr_data = n_ff;
      if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff[ADDR_W-1:0];
         wr_data = '0;
      end else if (cmd.commit) begin
         if (op_ff == OP_FREE) begin
            wr_en   = 1'b1;
            wr_addr = fs_ff;
            wr_data = '0;
         end else begin
            wr_en = ok_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + CNT_W'(1);
         end
         if (cmd.commit && (op_ff == OP_ALLOC) && ok_ff && (policy == POL_NEXT)) begin
            ptr_ff <= (np >= (SIZE_W+1)'(POOL_UNITS)) ? '0 : np[ADDR_W-1:0];
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= in_op;
         n_ff  <= in_size;
         fs_ff <= in_free_start;
      end
      u_ff          <= u_in;
      run_ff        <= run_in;
      rs_ff         <= rs_in;
      best_found_ff <= best_found_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      low_found_ff  <= low_found_in;
      low_start_ff  <= low_start_in;
      ok_ff         <= ok_in;
      start_ff      <= start_in;
      if (cmd.commit) begin
         rsp_granted_ff <= ok_ff;
         rsp_start_ff   <= start_ff;
      end
   end

   assign status.clr_done  = (clr_ff == CNT_W'(POOL_UNITS - 1));
   assign status.need_scan = (in_op == OP_ALLOC) && (in_size != '0)
                             && (in_size <= SIZE_W'(POOL_UNITS)) && (policy != POL_UNUSED);
   assign status.scan_done = done;
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_granted_ff;
   assign rsp_block_start = rsp_start_ff;
endmodule

>>> hw/rtl/contiguous_fit_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Contiguous first/next/best fit allocator over a pool of units.
// ----------------------------------------------------------------------------
// Usage: req_ch carries one item (op, req_size, free_start); rsp_ch returns one
// item (granted, block_start) for each. csr_* is an APB-style port holding the
// fit policy at address 0 (0 first, 1 next, 2 best fit).
// A free, or an allocate that cannot fit by its size or policy, skips the scan.
// An allocate scans the pool from unit zero, one free unit per cycle, and
// jumps over each allocated block by the size that the table holds for it.
// One item is in work at a time.
// After reset the size table is cleared in a pass over all POOL_UNITS entries,
// during which req_ch.ready stays low; csr writes are taken throughout.
// The result sits in an output register: a new item is accepted while it waits,
// but its result is not committed until rsp_ch.ready takes the previous one.
module contiguous_fit_allocator (
   input  logic                             clock,
   input  logic                             reset,
   cfa_req_if.sink                          req_ch,
   cfa_rsp_if.source                        rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cfa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cfa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cfa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import cfa_pkg::*;

   policy_type policy_ff;
   cmd_type    cmd;
   status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_FIRST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_FIT_POLICY) begin
         policy_ff <= policy_type'(csr_pwdata[POLICY_W-1:0]);
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_FIT_POLICY) ?
                       {{(CSR_DATA_W-POLICY_W){1'b0}}, policy_ff} : '0;

   cfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   cfa_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .policy          (policy_ff),
      .in_op           (req_ch.op),
      .in_size         (req_ch.req_size),
      .in_free_start   (req_ch.free_start),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_granted     (rsp_ch.granted),
      .rsp_block_start (rsp_ch.block_start)
   );
endmodule

>>> hw/rtl/cfa_checker.sv
// ----------------------------------------------------------------------------
// cfa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module cfa_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_granted,
   input logic [cfa_pkg::ADDR_W-1:0] rsp_block_start
);
   // one item in work: intake closes right after an accept
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("intake still open after accept");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_block_start == '0)
      else $error("refused item carries a start");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_start)
                                  && $stable(rsp_granted))
      else $error("stalled result changed");
endmodule

bind contiguous_fit_allocator cfa_checker u_cfa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_granted     (rsp_ch.granted),
   .rsp_block_start (rsp_ch.block_start)
);

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the contiguous fit allocator. Drives allocate and
// free items under first, next, best and unused fit policies. A local copy of
// the size table and next-fit pointer predicts every result. The results are
// compared in order, with random request gaps and result back-pressure.
// ----------------------------------------------------------------------------
module tb;
   import cfa_pkg::*;

   localparam int LIMIT_CYCLES = 4000000;
   localparam int RANDOM_ITEMS = 800;

   typedef struct packed {
      logic              granted;
      logic [ADDR_W-1:0] block_start;
   } grant_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   cfa_req_if req_if ();
   cfa_rsp_if rsp_if ();

   contiguous_fit_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if.sink),
      .rsp_ch      (rsp_if.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // local copy of the allocator state
   logic [SIZE_W-1:0] size_table [POOL_UNITS];
   logic [ADDR_W-1:0] fit_pointer;
   policy_type        fit_mode;
   bit                occupied [POOL_UNITS];
   int                live_starts [$];

   grant_type expected_grants [$];
   int        error_count;
   int        cycle_count;
   bit        hold_rsp;
   bit        gaps_on;
   int        burst_left;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL contiguous_fit_allocator");
         $finish;
      end
   end

   // receiver stall pattern: steps through always ready, mostly ready, mostly stalled and coin-flip phases
   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_if.ready <= 1'b0;
      end else begin
         case ((cycle_count / 128) % 4)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_if.ready <= $urandom_range(0, 1);
         endcase
      end
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // compare each result item with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_grants.size() == 0) begin
            report_mismatch("unexpected result", rsp_if.granted, 0);
         end else begin
            grant_type want;
            want = expected_grants.pop_front();
            if (rsp_if.granted !== want.granted)
               report_mismatch("granted", rsp_if.granted, want.granted);
            if (rsp_if.block_start !== want.block_start)
               report_mismatch("block_start", rsp_if.block_start, want.block_start);
         end
      end
   end

   function automatic bit find_window(int from, int n, output int start);
      int run;
      run = 0;
      for (int u = from; u < POOL_UNITS; u++) begin
         if (occupied[u]) begin
            run = 0;
         end else begin
            run++;
            if (run == n) begin
               start = u + 1 - n;
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic bit find_tightest_run(int n, output int start);
      int u, s, len, best_len;
      bit found;
      u = 0;
      found = 1'b0;
      best_len = 0;
      start = 0;
      while (u < POOL_UNITS) begin
         if (occupied[u]) begin
            u++;
         end else begin
            s = u;
            while (u < POOL_UNITS && !occupied[u]) u++;
            len = u - s;
            if (len >= n && (!found || len <= best_len)) begin
               found = 1'b1;
               best_len = len;
               start = s;
            end
         end
      end
      return found;
   endfunction

   function automatic grant_type predict_grant(op_type op, logic [SIZE_W-1:0] sz,
                                               logic [ADDR_W-1:0] fs);
      grant_type g;
      int start, n, top, p;
      bit ok;
      ok = 1'b0;
      start = 0;
      n = sz;
      if (op == OP_FREE) begin
         size_table[fs] = '0;
         foreach (live_starts[i]) begin
            if (live_starts[i] == fs) begin
               live_starts.delete(i);
               break;
            end
         end
         ok = 1'b1;
         start = fs;
      end else if (n != 0 && n <= POOL_UNITS && fit_mode != POL_UNUSED) begin
         for (int u = 0; u < POOL_UNITS; u++) occupied[u] = 1'b0;
         for (int s = 0; s < POOL_UNITS; s++) begin
            if (size_table[s] != 0) begin
               top = s + size_table[s];
               if (top > POOL_UNITS) top = POOL_UNITS;
               for (int u = s; u < top; u++) occupied[u] = 1'b1;
            end
         end
         if (fit_mode == POL_FIRST) begin
            ok = find_window(0, n, start);
         end else if (fit_mode == POL_NEXT) begin
            p = fit_pointer;
            ok = find_window(p, n, start);
            if (!ok) ok = find_window(0, n, start);
            if (ok) fit_pointer = (start + n >= POOL_UNITS) ? '0 : ADDR_W'(start + n);
         end else begin
            ok = find_tightest_run(n, start);
         end
         if (ok) begin
            size_table[start] = sz;
            live_starts.push_back(start);
         end
      end
      g.granted = ok;
      g.block_start = ok ? ADDR_W'(start) : '0;
      return g;
   endfunction

   // send one item; valid stays high for a following item unless a gap falls
   task automatic send_item(op_type op, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] fs);
      int gap;
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(1, 8);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left--;
      end
      req_if.valid      <= 1'b1;
      req_if.op         <= op;
      req_if.req_size   <= sz;
      req_if.free_start <= fs;
      do @(posedge clock); while (!req_if.ready);
      expected_grants.push_back(predict_grant(op, sz, fs));
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_policy(policy_type p);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_FIT_POLICY;
      csr_pwdata  <= CSR_DATA_W'(p);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      fit_mode = p;
   endtask

   task automatic send_random_item();
      int r;
      logic [SIZE_W-1:0] sz;
      logic [ADDR_W-1:0] fs;
      r = $urandom_range(0, 99);
      if (live_starts.size() == 0 || r < 55) begin
         r = $urandom_range(0, 99);
         if (r < 3) sz = '0;
         else if (r < 6) sz = SIZE_W'($urandom_range(1025, 2047));
         else if (r < 10) sz = SIZE_W'($urandom_range(512, 1024));
         else sz = SIZE_W'($urandom_range(1, 48));
         send_item(OP_ALLOC, sz, ADDR_W'($urandom_range(0, 1023)));
      end else begin
         if ($urandom_range(0, 99) < 80)
            fs = ADDR_W'(live_starts[$urandom_range(0, live_starts.size() - 1)]);
         else
            fs = ADDR_W'($urandom_range(0, 1023));
         send_item(OP_FREE, SIZE_W'($urandom_range(0, 2047)), fs);
      end
   endtask

   task automatic test_directed();
      gaps_on = 1'b0;
      send_item(OP_ALLOC, 11'd0, 10'd1023);
      send_item(OP_ALLOC, 11'd2047, 10'd0);
      send_item(OP_ALLOC, 11'd1024, 10'd0);
      send_item(OP_ALLOC, 11'd1, 10'd0);
      send_item(OP_FREE, 11'd2047, 10'd5);
      send_item(OP_FREE, 11'd0, 10'd0);
      send_item(OP_ALLOC, 11'd10, 10'd0);
      send_item(OP_ALLOC, 11'd20, 10'd0);
      send_item(OP_ALLOC, 11'd5, 10'd0);
      send_item(OP_FREE, 11'd0, 10'd10);
      send_item(OP_ALLOC, 11'd4, 10'd0);
      write_policy(POL_NEXT);
      send_item(OP_ALLOC, 11'd3, 10'd0);
      send_item(OP_ALLOC, 11'd900, 10'd0);
      send_item(OP_ALLOC, 11'd100, 10'd0);
      send_item(OP_ALLOC, 11'd2, 10'd0);
      write_policy(POL_BEST);
      send_item(OP_FREE, 11'd0, 10'd0);
      send_item(OP_ALLOC, 11'd3, 10'd0);
      send_item(OP_ALLOC, 11'd1, 10'd0);
      send_item(OP_ALLOC, 11'd1024, 10'd0);
      write_policy(POL_UNUSED);
      send_item(OP_ALLOC, 11'd1, 10'd0);
      send_item(OP_FREE, 11'd0, 10'd1023);
      write_policy(POL_FIRST);
      // drop every live block so the random part starts from an empty pool
      while (live_starts.size() != 0)
         send_item(OP_FREE, 11'd0, ADDR_W'(live_starts[0]));
   endtask

   task automatic test_random_policies();
      policy_type order [4];
      order = '{POL_FIRST, POL_NEXT, POL_BEST, POL_UNUSED};
      for (int ph = 0; ph < 8; ph++) begin
         gaps_on = (ph % 3 != 2);
         if (ph < 4) write_policy(order[ph]);
         else write_policy(policy_type'($urandom_range(0, 3)));
         repeat (RANDOM_ITEMS / 8) send_random_item();
      end
   endtask

   task automatic test_backpressure();
      write_policy(POL_FIRST);
      gaps_on = 1'b0;
      fork
         begin
            hold_rsp = 1'b1;
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
         end
         repeat (20) send_item(OP_FREE, 11'd0, ADDR_W'($urandom_range(0, 1023)));
      join
   endtask

   task automatic test_drain_pause();
      gaps_on = 1'b1;
      repeat (10) send_random_item();
      wait_idle();
      repeat (10) send_random_item();
   endtask

   initial begin
      reset        = 1'b1;
      error_count  = 0;
      hold_rsp     = 1'b0;
      gaps_on      = 1'b0;
      burst_left   = 0;
      fit_pointer  = '0;
      fit_mode     = POL_FIRST;
      for (int u = 0; u < POOL_UNITS; u++) size_table[u] = '0;
      req_if.valid      = 1'b0;
      req_if.op         = OP_ALLOC;
      req_if.req_size   = '0;
      req_if.free_start = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_policies();
      test_backpressure();
      test_drain_pause();
      req_if.valid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS contiguous_fit_allocator");
      end else begin
         $display("FAIL contiguous_fit_allocator");
      end
      $finish;
   end
endmodule
